### src/dmm_pkg.sv
// ---------------------------------------------------------------------------
// dmm_pkg
// Shared sizes, codes and types of the dense matrix multiply with bias.
// ---------------------------------------------------------------------------
package dmm_pkg;

  // build sizes
  localparam int ROWS   = 16;
  localparam int COLS   = 64;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;

  // field widths
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 40;
  localparam int BIAS_SH = 15;
  localparam int AROW_W  = 7;
  localparam int ACOL_W  = 9;
  localparam int IROW_W  = 6;
  localparam int ICOL_W  = 8;

  // configuration register reset values
  localparam logic [AROW_W-1:0] ROWS_RST = AROW_W'(16);
  localparam logic [ACOL_W-1:0] COLS_RST = ACOL_W'(64);

  // register index (paddr bit 2)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // request kinds
  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_BIAS   = 2'd1,
    REQ_ELEM   = 2'd2
  } req_t;

  // controller state
  typedef enum logic [1:0] {
    ST_ACC,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

  // control group broadcast from the controller to every cell
  typedef struct packed {
    logic                    wt_we;
    logic                    bias_we;
    logic [ROW_W-1:0]        wr_row;
    logic [COL_W-1:0]        wr_col;
    logic signed [VAL_W-1:0] wr_val;
    logic                    rd_en;
    logic [COL_W-1:0]        rd_pos;
    logic signed [VAL_W-1:0] x;
    logic                    s1_v;
    logic                    s2_v;
    logic                    s2_first;
    logic                    load;
    logic                    shift;
  } cell_ctl_t;

endpackage

### src/dmm_cell.sv
// ---------------------------------------------------------------------------
// dmm_cell
// One row of the product: weight column memory, bias word, multiply,
// accumulator and one stage of the result shift chain.
// ---------------------------------------------------------------------------
module dmm_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [dmm_pkg::ROW_W-1:0]            cell_row,
  input  dmm_pkg::cell_ctl_t                   ctl,
  input  logic signed [dmm_pkg::SUM_W-1:0]     sum_in,
  output logic signed [dmm_pkg::SUM_W-1:0]     sum_out
);

  logic signed [dmm_pkg::VAL_W-1:0]  wt_mem [dmm_pkg::COLS];
  logic signed [dmm_pkg::VAL_W-1:0]  w_r;
  logic signed [dmm_pkg::VAL_W-1:0]  bias_r;
  logic signed [dmm_pkg::VAL_W-1:0]  bias_s1_r;
  logic signed [dmm_pkg::PROD_W-1:0] prod_r;
  logic signed [dmm_pkg::SUM_W-1:0]  base_r;
  logic signed [dmm_pkg::SUM_W-1:0]  acc_r;
  logic signed [dmm_pkg::SUM_W-1:0]  acc_nxt;
  logic signed [dmm_pkg::SUM_W-1:0]  sum_r;
  logic                              sel;

  assign sel = (ctl.wr_row == cell_row);

  // weight column memory, read once per element
  always_ff @(posedge clk) begin
    if (ctl.wt_we && sel) begin
      wt_mem[ctl.wr_col] <= ctl.wr_val;
    end
    if (ctl.rd_en) begin
      w_r <= wt_mem[ctl.rd_pos];
    end
  end

  // bias word; sampled alongside the weight read
  always_ff @(posedge clk) begin
    if (ctl.bias_we && sel) begin
      bias_r <= ctl.wr_val;
    end
    if (ctl.rd_en) begin
      bias_s1_r <= bias_r;
    end
  end

  // product and bias scaled to Q.30
  always_ff @(posedge clk) begin
    if (ctl.s1_v) begin
      prod_r <= w_r * ctl.x;
      base_r <= {{(dmm_pkg::SUM_W - dmm_pkg::VAL_W - dmm_pkg::BIAS_SH){bias_s1_r[dmm_pkg::VAL_W-1]}},
                 bias_s1_r, {dmm_pkg::BIAS_SH{1'b0}}};
    end
  end

  // accumulate; the first element of a column restarts from the bias
  always_comb begin
    acc_nxt = (ctl.s2_first ? base_r : acc_r)
            + {{(dmm_pkg::SUM_W - dmm_pkg::PROD_W){prod_r[dmm_pkg::PROD_W-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.s2_v) begin
      acc_r <= acc_nxt;
    end
  end

  // result chain: capture the sum, then hand it towards cell 0
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum_r <= acc_r;
    end else if (ctl.shift) begin
      sum_r <= sum_in;
    end
  end

  assign sum_out = sum_r;

endmodule

### src/dmm_ctrl.sv
// ---------------------------------------------------------------------------
// dmm_ctrl
// Configuration registers, request decode, element pipeline flags and the
// result drain sequencer.
// ---------------------------------------------------------------------------
module dmm_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  // request item
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [1:0]                         req_type,
  input  logic [dmm_pkg::IROW_W-1:0]         row_index,
  input  logic [dmm_pkg::ICOL_W-1:0]         col_index,
  input  logic signed [dmm_pkg::VAL_W-1:0]   value,
  // result item control
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dmm_pkg::ROW_W-1:0]          out_row,
  output logic                               out_last,
  // to the cells
  output dmm_pkg::cell_ctl_t                 ctl
);

  logic [dmm_pkg::AROW_W-1:0]       rows_r;
  logic [dmm_pkg::ACOL_W-1:0]       cols_r;
  logic [dmm_pkg::AROW_W-1:0]       nrows;
  logic [dmm_pkg::ACOL_W-1:0]       ncols;
  logic [dmm_pkg::COL_W-1:0]        count_r;
  logic [dmm_pkg::COL_W-1:0]        count_nxt;
  logic [dmm_pkg::ROW_W-1:0]        drn_r;
  logic [dmm_pkg::ROW_W-1:0]        drn_nxt;
  dmm_pkg::state_t                  state_r;
  dmm_pkg::state_t                  state_nxt;
  logic signed [dmm_pkg::VAL_W-1:0] x_r;
  logic                             s1_v_r, s1_first_r, s1_close_r;
  logic                             s2_v_r, s2_first_r, s2_close_r;
  logic                             s3_close_r;
  logic                             cfg_we;
  logic                             acc_in;
  logic                             is_wt, is_bias, is_elem;
  logic                             closing;
  logic                             out_take;
  logic                             row_ok, col_ok;

  // configuration port
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= dmm_pkg::ROWS_RST;
      cols_r <= dmm_pkg::COLS_RST;
    end else if (cfg_we) begin
      if (cfg_paddr[2] == dmm_pkg::REG_ROWS) begin
        rows_r <= cfg_pwdata[dmm_pkg::AROW_W-1:0];
      end else begin
        cols_r <= cfg_pwdata[dmm_pkg::ACOL_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == dmm_pkg::REG_COLS)
                    ? {{(32 - dmm_pkg::ACOL_W){1'b0}}, cols_r}
                    : {{(32 - dmm_pkg::AROW_W){1'b0}}, rows_r};

  // clipped sizes
  always_comb begin
    priority if (rows_r == '0) begin
      nrows = dmm_pkg::AROW_W'(1);
    end else if (rows_r > dmm_pkg::AROW_W'(dmm_pkg::ROWS)) begin
      nrows = dmm_pkg::AROW_W'(dmm_pkg::ROWS);
    end else begin
      nrows = rows_r;
    end
    priority if (cols_r == '0) begin
      ncols = dmm_pkg::ACOL_W'(1);
    end else if (cols_r > dmm_pkg::ACOL_W'(dmm_pkg::COLS)) begin
      ncols = dmm_pkg::ACOL_W'(dmm_pkg::COLS);
    end else begin
      ncols = cols_r;
    end
  end

  // request decode
  assign acc_in = in_tvalid && in_tready;

  always_comb begin
    is_wt   = 1'b0;
    is_bias = 1'b0;
    is_elem = 1'b0;
    unique case (dmm_pkg::req_t'(req_type))
      dmm_pkg::REQ_WEIGHT: is_wt   = 1'b1;
      dmm_pkg::REQ_BIAS:   is_bias = 1'b1;
      dmm_pkg::REQ_ELEM:   is_elem = 1'b1;
      default: ;
    endcase
  end

  assign row_ok  = ({1'b0, row_index} < (dmm_pkg::IROW_W + 1)'(dmm_pkg::ROWS));
  assign col_ok  = ({1'b0, col_index} < (dmm_pkg::ICOL_W + 1)'(dmm_pkg::COLS));
  assign closing = ((dmm_pkg::ACOL_W'(count_r) + dmm_pkg::ACOL_W'(1)) >= ncols);

  // element pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_first_r <= 1'b0;
      s1_close_r <= 1'b0;
      s2_v_r     <= 1'b0;
      s2_first_r <= 1'b0;
      s2_close_r <= 1'b0;
      s3_close_r <= 1'b0;
    end else begin
      s1_v_r     <= acc_in && is_elem;
      s1_first_r <= (count_r == '0);
      s1_close_r <= acc_in && is_elem && closing;
      s2_v_r     <= s1_v_r;
      s2_first_r <= s1_first_r;
      s2_close_r <= s1_close_r;
      s3_close_r <= s2_close_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && is_elem) begin
      x_r <= value;
    end
  end

  // state, element count and drain row registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmm_pkg::ST_ACC;
      count_r <= '0;
      drn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drn_r   <= drn_nxt;
    end
  end

  assign out_take = out_tvalid && out_tready;
  assign out_last = ((dmm_pkg::AROW_W'(drn_r) + dmm_pkg::AROW_W'(1)) == nrows);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    drn_nxt    = drn_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      dmm_pkg::ST_ACC: begin
        in_tready = 1'b1;
        if (acc_in && is_elem) begin
          if (closing) begin
            count_nxt = '0;
            state_nxt = dmm_pkg::ST_FLUSH;
          end else begin
            count_nxt = count_r + dmm_pkg::COL_W'(1);
          end
        end
      end
      dmm_pkg::ST_FLUSH: begin
        if (s3_close_r) begin
          drn_nxt   = '0;
          state_nxt = dmm_pkg::ST_DRAIN;
        end
      end
      dmm_pkg::ST_DRAIN: begin
        out_tvalid = 1'b1;
        if (out_take) begin
          if (out_last) begin
            state_nxt = dmm_pkg::ST_ACC;
          end else begin
            drn_nxt = drn_r + dmm_pkg::ROW_W'(1);
          end
        end
      end
      default: state_nxt = dmm_pkg::ST_ACC;
    endcase
  end

  assign out_row = drn_r;

  // control group to the cells
  always_comb begin
    ctl          = '0;
    ctl.wt_we    = acc_in && is_wt && row_ok && col_ok;
    ctl.bias_we  = acc_in && is_bias && row_ok;
    ctl.wr_row   = row_index[dmm_pkg::ROW_W-1:0];
    ctl.wr_col   = col_index[dmm_pkg::COL_W-1:0];
    ctl.wr_val   = value;
    ctl.rd_en    = acc_in && is_elem;
    ctl.rd_pos   = count_r;
    ctl.x        = x_r;
    ctl.s1_v     = s1_v_r;
    ctl.s2_v     = s2_v_r;
    ctl.s2_first = s2_first_r;
    ctl.load     = s3_close_r;
    ctl.shift    = out_take;
  end

`ifndef SYNTHESIS
  // never take an item while results are on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while draining");

  // sums are captured only while waiting for the pipeline
  a_load_flush: assert property (@(posedge clk) disable iff (!rst_n)
    s3_close_r |-> (state_r == dmm_pkg::ST_FLUSH))
    else $error("chain load outside flush");

  // pipeline is empty once draining
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmm_pkg::ST_DRAIN) |-> (!s1_v_r && !s2_v_r && !s2_close_r))
    else $error("element in flight during drain");

  // taking the final row returns to accepting items
  a_last_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last) |=> (state_r == dmm_pkg::ST_ACC && drn_r == $past(drn_r)))
    else $error("drain did not end on last row");
`endif

endmodule

### src/dense_matrix_multiply_bias.sv
// ---------------------------------------------------------------------------
// dense_matrix_multiply_bias
// Y = W*X + b one column at a time on a row of multiply-accumulate cells.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser req_type; tdata row,col,value
//  out_     out  out_tvalid/out_tready  tdata out_row,row_sum; tlast last_row
//  cfg_     in   APB, pready tied high  active_rows @0, active_cols @4
//
// Loads and elements are taken one per cycle outside flush and drain; every
// cell multiplies the element against its own weight column in parallel.
// The first sum is on offer once the closing element of a column has been
// taken and passed through the weight read (at the taking edge), multiply,
// accumulate and capture; then one sum per cycle leaves through the cell
// chain while out_tready is high. Input is held off from the closing element
// until the last sum is taken. Output stalls simply hold the chain.
// Reset (rst_n low, synchronous) clears control and accumulators; weight
// and bias stores hold nothing defined until loaded.
// ---------------------------------------------------------------------------
module dense_matrix_multiply_bias (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // request items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [5:0] row_index, [13:6] col_index, [29:14] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [5:0] out_row, [45:6] row_sum
  output logic        out_tlast   // last_row
);

  dmm_pkg::cell_ctl_t                ctl;
  logic [dmm_pkg::ROW_W-1:0]         drn_row;
  logic signed [dmm_pkg::SUM_W-1:0]  chain [dmm_pkg::ROWS+1];

  assign cfg_pready = 1'b1;

  dmm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .req_type    (in_tuser),
    .row_index   (in_tdata[5:0]),
    .col_index   (in_tdata[13:6]),
    .value       (in_tdata[29:14]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_row     (drn_row),
    .out_last    (out_tlast),
    .ctl         (ctl)
  );

  // row of cells; sums travel towards cell 0
  assign chain[dmm_pkg::ROWS] = '0;

  for (genvar i = 0; i < dmm_pkg::ROWS; i++) begin : g_cell
    dmm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_row (dmm_pkg::ROW_W'(i)),
      .ctl      (ctl),
      .sum_in   (chain[i+1]),
      .sum_out  (chain[i])
    );
  end

  // result packing
  assign out_tdata = {2'b00, chain[0], (dmm_pkg::IROW_W)'(drn_row)};

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dense matrix multiply with bias.
// Loads every bias and the leading weight columns of every row, then streams
// vector elements under a range of active sizes, keeping the element position
// inside the loaded columns. A behavioural copy of the multiply-accumulate
// array predicts every row sum, and each result item is compared against it
// while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  import dmm_pkg::*;

  localparam int          CLK_PERIOD   = 20;
  localparam int          RESET_CYCLES = 6;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASES       = 4;
  localparam int          PHASE_ITEMS  = 4;
  localparam int          PRELOAD_COLS = 4;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic signed [VAL_W-1:0] Q15_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] Q15_MAX = 16'sh7FFF;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  typedef struct {
    logic [IROW_W-1:0]       row;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } row_result_t;

  // DUT ports, all driven from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;   // [5:0] row_index, [13:6] col_index, [29:14] value
  logic [1:0]  in_tuser    = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;          // [5:0] out_row, [45:6] row_sum
  logic        out_tlast;

  // predictor state
  logic signed [VAL_W-1:0] weight_mem [ROWS*COLS];
  logic signed [VAL_W-1:0] bias_mem   [ROWS];
  longint                  row_acc    [ROWS];
  int unsigned             elem_pos   = 0;
  logic [AROW_W-1:0]       rows_reg   = ROWS_RST;
  logic [ACOL_W-1:0]       cols_reg   = COLS_RST;
  row_result_t             pending_sums [$];

  // bookkeeping
  int          errors         = 0;
  int          items_sent     = 0;
  int          sums_checked   = 0;
  int          columns_closed = 0;
  int          burst_left     = 0;
  int          cycle_count    = 0;
  rx_mode_t    rx_mode        = RX_OPEN;
  int          rx_left        = 0;
  int unsigned rx_tick        = 0;
  row_result_t want;

  dense_matrix_multiply_bias dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d sums outstanding",
               $time, CYCLE_LIMIT, pending_sums.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: back-pressure in changing modes
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_tready = 1'b1;
      RX_CHOPPY: out_tready = ($urandom_range(0, 2) != 0);
      default:   out_tready = (rx_tick % 4 == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected sum, expected none, actual row %0d sum %0d last %0b",
                 $time, out_tdata[5:0], $signed(out_tdata[45:6]), out_tlast);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        sums_checked++;
        if (out_tdata[5:0] !== want.row) begin
          $display("%0t: out_row mismatch, expected %0d actual %0d",
                   $time, want.row, out_tdata[5:0]);
          errors++;
        end
        if (out_tdata[45:6] !== want.sum) begin
          $display("%0t: row_sum mismatch on row %0d, expected %0d actual %0d",
                   $time, want.row, want.sum, $signed(out_tdata[45:6]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_row mismatch on row %0d, expected %0b actual %0b",
                   $time, want.row, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned clamp_active(int unsigned n, int unsigned limit);
    if (n == 0) return 1;
    return (n > limit) ? limit : n;
  endfunction

  // mirror of the MAC array: update stores, accumulate, queue the row sums
  task automatic accumulate_item(input logic [1:0] kind, input logic [IROW_W-1:0] row,
                                 input logic [ICOL_W-1:0] col,
                                 input logic signed [VAL_W-1:0] val);
    int unsigned nrows;
    int unsigned ncols;
    int unsigned pos;
    row_result_t res;
    case (kind)
      REQ_WEIGHT: if (row < ROWS && col < COLS) weight_mem[row * COLS + col] = val;
      REQ_BIAS:   if (row < ROWS) bias_mem[row] = val;
      REQ_ELEM: begin
        nrows = clamp_active(rows_reg, ROWS);
        ncols = clamp_active(cols_reg, COLS);
        pos   = (elem_pos >= COLS) ? COLS - 1 : elem_pos;
        for (int r = 0; r < ROWS; r++) begin
          if (elem_pos == 0) row_acc[r] = longint'(bias_mem[r]) <<< BIAS_SH;
          row_acc[r] += longint'(weight_mem[r * COLS + pos]) * longint'(val);
        end
        if (elem_pos + 1 >= ncols) begin
          elem_pos = 0;
          columns_closed++;
          for (int r = 0; r < nrows; r++) begin
            res.row  = r[IROW_W-1:0];
            res.sum  = row_acc[r][SUM_W-1:0];
            res.last = (r + 1 == nrows);
            pending_sums.push_back(res);
          end
        end else begin
          elem_pos = (elem_pos + 1) & 8'hFF;
        end
      end
      default: ;
    endcase
  endtask

  // one request item, with random gaps between bursts; returns at a falling edge
  task automatic send_item(input logic [1:0] kind, input logic [IROW_W-1:0] row,
                           input logic [ICOL_W-1:0] col,
                           input logic signed [VAL_W-1:0] val);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_tuser  = kind;
    in_tdata  = {2'b00, val, col, row};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    accumulate_item(kind, row, col, val);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_q15();
    case ($urandom_range(0, 11))
      0:       return Q15_MIN;
      1:       return Q15_MAX;
      2:       return '0;
      3:       return -16'sd1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // wait for every queued sum, then let the pipeline run dry
  task automatic settle_outputs();
    in_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_ROWS) rows_reg = value[AROW_W-1:0];
    else                 cols_reg = value[ACOL_W-1:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_sizes(input int unsigned nrows, input int unsigned ncols);
    settle_outputs();
    write_reg(REG_ROWS, nrows);
    write_reg(REG_COLS, ncols);
  endtask

  task automatic send_element(input logic signed [VAL_W-1:0] val);
    send_item(REQ_ELEM, IROW_W'($urandom), ICOL_W'($urandom), val);
  endtask

  // every bias and the leading weight columns written before any element reads them
  task automatic test_preload();
    for (int r = 0; r < ROWS; r++)
      send_item(REQ_BIAS, r[IROW_W-1:0], ICOL_W'($urandom), rand_q15());
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < PRELOAD_COLS; c++)
        send_item(REQ_WEIGHT, r[IROW_W-1:0], c[ICOL_W-1:0], rand_q15());
  endtask

  // elements at the sizes left by reset keep the column open; a shorter
  // column count then closes it with the reset row count
  task automatic test_reset_sizes();
    for (int i = 0; i < PRELOAD_COLS - 1; i++) send_element(rand_q15());
    settle_outputs();
    write_reg(REG_COLS, PRELOAD_COLS);
    send_element(rand_q15());
  endtask

  // full-scale operands on the first and last rows
  task automatic test_extremes();
    set_sizes(ROWS, 2);
    send_item(REQ_BIAS,   0,                  0, Q15_MAX);
    send_item(REQ_BIAS,   IROW_W'(ROWS - 1),  0, Q15_MIN);
    send_item(REQ_WEIGHT, 0,                  0, Q15_MIN);
    send_item(REQ_WEIGHT, 0,                  1, Q15_MIN);
    send_item(REQ_WEIGHT, IROW_W'(ROWS - 1),  0, Q15_MAX);
    send_item(REQ_WEIGHT, IROW_W'(ROWS - 1),  1, Q15_MAX);
    send_element(Q15_MIN);
    send_element(Q15_MIN);
    send_element(Q15_MAX);
    send_element('0);
  endtask

  // zero sizes act as one, oversized ones clip to the build
  task automatic test_size_clipping();
    set_sizes(0, 0);
    send_element(rand_q15());
    send_element(rand_q15());
    set_sizes(127, 1);
    send_element(rand_q15());
  endtask

  // column count dropped to the current position closes the column
  task automatic test_mid_column_resize();
    set_sizes(3, 511);
    repeat (2) send_element(rand_q15());
    set_sizes(3, 2);
    send_element(rand_q15());
  endtask

  // unknown requests and out-of-range loads must leave the stores alone
  task automatic test_ignored_requests();
    set_sizes(4, 1);
    send_item(REQ_UNUSED, '1, '1, Q15_MIN);
    send_item(REQ_WEIGHT, 20, 3,   Q15_MAX);
    send_item(REQ_WEIGHT, 2,  200, Q15_MAX);
    send_item(REQ_WEIGHT, 63, 255, Q15_MIN);
    send_item(REQ_BIAS,   IROW_W'(ROWS), 0, Q15_MAX);
    send_item(REQ_BIAS,   40, 0,   Q15_MIN);
    send_item(REQ_ELEM,   '1, '1,  Q15_MAX);
  endtask

  // mostly elements with in-range reloads mixed in, plus some noise;
  // column counts stay within the loaded weight columns
  task automatic test_random_traffic();
    int unsigned row_edges [6] = '{0, 1, ROWS, ROWS + 1, 64, 127};
    int unsigned col_edges [3] = '{0, 1, PRELOAD_COLS};
    int unsigned nrows;
    int unsigned ncols;
    int unsigned pick;
    for (int p = 0; p < PHASES; p++) begin
      nrows = ($urandom_range(0, 3) == 0) ? row_edges[$urandom_range(0, 5)]
                                          : $urandom_range(1, ROWS);
      ncols = ($urandom_range(0, 4) == 0) ? col_edges[$urandom_range(0, 2)]
                                          : $urandom_range(1, PRELOAD_COLS);
      set_sizes(nrows, ncols);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_element(rand_q15());
        else if (pick < 85)
          send_item(pick[0] ? REQ_WEIGHT : REQ_BIAS,
                    IROW_W'($urandom_range(0, ROWS - 1)),
                    ICOL_W'($urandom_range(0, COLS - 1)), rand_q15());
        else if (pick < 92)
          send_item(REQ_UNUSED, IROW_W'($urandom), ICOL_W'($urandom), rand_q15());
        else
          send_item(pick[0] ? REQ_WEIGHT : REQ_BIAS, IROW_W'($urandom),
                    ICOL_W'($urandom), rand_q15());
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    test_preload();
    test_reset_sizes();
    test_extremes();
    test_size_clipping();
    test_mid_column_resize();
    test_ignored_requests();
    test_random_traffic();
    settle_outputs();
    $display("Sent %0d request items over %0d closed columns; %0d row sums checked, %0d errors",
             items_sent, columns_closed, sums_checked, errors);
    if (errors == 0) $display("Regression PASS");
    else             $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
src/dmm_pkg.sv
src/dmm_cell.sv
src/dmm_ctrl.sv
src/dense_matrix_multiply_bias.sv
verif/tb_top.sv
